[hdl/mi_pkg.sv]
// Package with the shared types and constants of the modular inverse block.
package mi_pkg;

    localparam int unsigned MI_WIDTH = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_CHECK,
        S_DIV,
        S_FINAL,
        S_FIX
    } t_mi_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[hdl/mi_serdiv.sv]
// Bit-serial restoring divider with a quotient-driven multiply-accumulate.
module mi_serdiv
    import mi_pkg::*;
#(
    parameter int unsigned WIDTH = MI_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    input  logic [WIDTH-1:0] i_mcand,
    output t_div_stat        o_stat,
    output logic [WIDTH-1:0] o_rem,
    output logic [WIDTH-1:0] o_prod
);

    localparam int unsigned CW = $clog2(WIDTH);

    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_dvd;
    logic [WIDTH-1:0] r_acc;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [WIDTH:0]   trial;
    logic [WIDTH-1:0] diff;
    logic             qbit;
    logic [WIDTH-1:0] n_rem;
    logic [WIDTH-1:0] n_acc;

    always_comb begin
        trial = {r_rem, r_dvd[WIDTH-1]};
        diff  = trial[WIDTH-1:0] - i_divisor;
        qbit  = (trial >= {1'b0, i_divisor});
        n_rem = qbit ? diff : trial[WIDTH-1:0];
        n_acc = {r_acc[WIDTH-2:0], 1'b0} + (qbit ? i_mcand : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_acc <= '0;
            r_dvd <= i_dividend;
            r_cnt <= CW'(WIDTH - 1);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_acc <= n_acc;
            r_dvd <= {r_dvd[WIDTH-2:0], 1'b0};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_rem  = r_rem;
    assign o_prod = r_acc;

endmodule

[hdl/modular_inverse.sv]
// Top level of the modular inverse block using the extended Euclidean algorithm.
//
// Channel   Direction  Ports                        Transaction
// command   in         start, busy, i_value         start high while busy low
// result    out        o_done, o_inverse,           o_done high for one cycle
//                      o_no_inverse
// config    in         i_modulus_we, i_modulus      i_modulus_we high
//
// Each Euclid iteration runs one division in the bit-serial divider, and
// the first reduction of the value modulo the modulus runs one as well.
// A modulus of zero gives its result in the cycle after the start.
// Reset is synchronous and active low and returns the modulus to one.
// The receiver cannot stall; each result is shown for exactly one cycle.
module modular_inverse
    import mi_pkg::*;
#(
    parameter int unsigned WIDTH = MI_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [WIDTH-1:0] i_value,
    input  logic             i_modulus_we,
    input  logic [WIDTH-1:0] i_modulus,
    output logic             o_done,
    output logic [WIDTH-1:0] o_inverse,
    output logic             o_no_inverse
);

    t_mi_state        r_state;
    t_mi_state        n_state;

    logic [WIDTH-1:0] r_modulus;
    logic [WIDTH-1:0] r_m;
    logic [WIDTH-1:0] r_r0;
    logic [WIDTH-1:0] r_r1;
    logic [WIDTH-1:0] r_c0;
    logic [WIDTH-1:0] r_c1;
    logic             r_neg0;
    logic             r_neg1;
    logic             r_done;
    logic [WIDTH-1:0] r_inv;
    logic             r_flag;

    logic             div_start;
    logic [WIDTH-1:0] div_dividend;
    logic [WIDTH-1:0] div_divisor;
    logic [WIDTH-1:0] div_mcand;
    t_div_stat        div_stat;
    logic [WIDTH-1:0] div_rem;
    logic [WIDTH-1:0] div_prod;

    logic             accept;

    assign accept = start && (r_state == S_IDLE);

    mi_serdiv #(
        .WIDTH (WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_mcand    (div_mcand),
        .o_stat     (div_stat),
        .o_rem      (div_rem),
        .o_prod     (div_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        div_start    = 1'b0;
        div_dividend = r_r0;
        div_divisor  = r_r1;
        div_mcand    = r_c1;
        unique case (r_state)
            S_IDLE: begin
                div_dividend = i_value;
                if (accept && (r_modulus != '0)) begin
                    div_start = 1'b1;
                    n_state   = S_REDUCE;
                end
            end
            S_REDUCE: begin
                div_divisor = r_m;
                div_mcand   = '0;
                if (div_stat.done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_r1 == '0) begin
                    n_state = S_FINAL;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    n_state = S_CHECK;
                end
            end
            S_FINAL: begin
                n_state = S_FIX;
            end
            S_FIX: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= WIDTH'(1);
        end else if (i_modulus_we) begin
            r_modulus <= i_modulus;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == S_FIX) || (accept && (r_modulus == '0));
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_m   <= r_modulus;
                    r_inv <= '0;
                    r_flag <= 1'b1;
                end
            end
            S_REDUCE: begin
                if (div_stat.done) begin
                    r_r0   <= r_m;
                    r_r1   <= div_rem;
                    r_c0   <= '0;
                    r_c1   <= WIDTH'(1);
                    r_neg0 <= 1'b0;
                    r_neg1 <= 1'b0;
                end
            end
            S_CHECK: begin
            end
            S_DIV: begin
                if (div_stat.done) begin
                    r_r0   <= r_r1;
                    r_r1   <= div_rem;
                    r_c0   <= r_c1;
                    r_c1   <= div_prod + r_c0;
                    r_neg0 <= r_neg1;
                    r_neg1 <= !r_neg1;
                end
            end
            S_FINAL: begin
                if (r_c0 >= r_m) begin
                    r_c0 <= r_c0 - r_m;
                end
            end
            S_FIX: begin
                if (r_r0 != WIDTH'(1)) begin
                    r_inv  <= '0;
                    r_flag <= 1'b1;
                end else begin
                    r_inv  <= (r_neg0 && (r_c0 != '0)) ? (r_m - r_c0) : r_c0;
                    r_flag <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    assign busy         = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_inverse    = r_inv;
    assign o_no_inverse = r_flag;

    a_start_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (r_modulus != '0) |=> busy)
        else $error("Accepted transaction did not start the computation.");

    a_remainder_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_r1 < r_r0))
        else $error("Remainder sequence is not decreasing.");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("Divider started while still running.");

    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_no_inverse |-> (o_inverse == '0))
        else $error("Flagged result carries a nonzero inverse.");

    a_inv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_no_inverse |-> (o_inverse < r_m))
        else $error("Inverse is not below the modulus.");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the modular inverse block, with directed rows and random phases.
module tb_top
    import mi_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [MI_WIDTH-1:0] t_word;

    typedef struct packed {
        t_word inverse;
        logic  no_inverse;
    } t_inv_result;

    typedef struct packed {
        logic  load;
        t_word modulus;
        t_word value;
        logic  typed;
        t_word inverse;
        logic  no_inverse;
    } t_row;

    localparam int N_ROWS = 21;
    localparam int N_PHASES = 10;
    localparam int PHASE_ITEMS = 40;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES = 2000;
    localparam t_word WORD_MAX = '1;
    localparam t_word BIG_PRIME = 32'd4294967291;
    localparam t_word FIB_47 = 32'd2971215073;
    localparam t_word FIB_46 = 32'd1836311903;

    localparam t_row DIRECTED [N_ROWS] = '{
        '{1'b0, 32'd0, 32'd0, 1'b1, 32'd0, 1'b0},
        '{1'b0, 32'd0, WORD_MAX, 1'b1, 32'd0, 1'b0},
        '{1'b1, 32'd0, 32'd5, 1'b1, 32'd0, 1'b1},
        '{1'b0, 32'd0, 32'd0, 1'b1, 32'd0, 1'b1},
        '{1'b1, 32'd7, 32'd0, 1'b1, 32'd0, 1'b1},
        '{1'b0, 32'd0, 32'd1, 1'b1, 32'd1, 1'b0},
        '{1'b0, 32'd0, 32'd3, 1'b1, 32'd5, 1'b0},
        '{1'b0, 32'd0, 32'd7, 1'b1, 32'd0, 1'b1},
        '{1'b0, 32'd0, WORD_MAX, 1'b0, 32'd0, 1'b0},
        '{1'b1, WORD_MAX, 32'd1, 1'b1, 32'd1, 1'b0},
        '{1'b0, 32'd0, WORD_MAX - 1, 1'b1, WORD_MAX - 1, 1'b0},
        '{1'b0, 32'd0, 32'd3, 1'b1, 32'd0, 1'b1},
        '{1'b0, 32'd0, 32'd2, 1'b0, 32'd0, 1'b0},
        '{1'b0, 32'd0, 32'd0, 1'b1, 32'd0, 1'b1},
        '{1'b1, 32'd2, WORD_MAX, 1'b1, 32'd1, 1'b0},
        '{1'b0, 32'd0, 32'd2, 1'b1, 32'd0, 1'b1},
        '{1'b1, BIG_PRIME, 32'h8000_0000, 1'b0, 32'd0, 1'b0},
        '{1'b0, 32'd0, 32'hAAAA_AAAA, 1'b0, 32'd0, 1'b0},
        '{1'b1, 32'h8000_0000, 32'h5555_5555, 1'b0, 32'd0, 1'b0},
        '{1'b0, 32'd0, 32'h8000_0001, 1'b0, 32'd0, 1'b0},
        '{1'b1, FIB_47, FIB_46, 1'b0, 32'd0, 1'b0}
    };

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_word i_value;
    logic  i_modulus_we;
    t_word i_modulus;
    logic  o_done;
    t_word o_inverse;
    logic  o_no_inverse;

    t_inv_result pending_results[$];
    t_word modulus_now;
    int error_count = 0;
    int checked_count = 0;
    int flagged_count = 0;
    int modulus_loads = 0;
    int idle_cycles = 0;

    modular_inverse dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_value      (i_value),
        .i_modulus_we (i_modulus_we),
        .i_modulus    (i_modulus),
        .o_done       (o_done),
        .o_inverse    (o_inverse),
        .o_no_inverse (o_no_inverse)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_inv_result calc_inverse(input t_word m, input t_word a);
        logic [63:0] r_prev, r_cur, r_next, c_prev, c_cur, c_next, quo;
        logic neg_prev, neg_cur, neg_next;
        t_inv_result res;
        res.inverse = '0;
        res.no_inverse = 1'b1;
        if (m == '0) begin
            return res;
        end
        r_prev = 64'(m);
        r_cur = 64'(a % m);
        c_prev = 64'd0;
        c_cur = 64'd1;
        neg_prev = 1'b0;
        neg_cur = 1'b0;
        while (r_cur != 64'd0) begin
            quo = r_prev / r_cur;
            r_next = r_prev - quo * r_cur;
            c_next = c_prev + quo * c_cur;
            neg_next = !neg_cur;
            r_prev = r_cur;
            r_cur = r_next;
            c_prev = c_cur;
            c_cur = c_next;
            neg_prev = neg_cur;
            neg_cur = neg_next;
        end
        if (r_prev != 64'd1) begin
            return res;
        end
        c_prev = c_prev % 64'(m);
        if (neg_prev && c_prev != 64'd0) begin
            res.inverse = m - t_word'(c_prev);
        end else begin
            res.inverse = t_word'(c_prev);
        end
        res.no_inverse = 1'b0;
        return res;
    endfunction

    task automatic send_value(input t_word v, input int gap, input t_inv_result want);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(want);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic load_modulus(input t_word m);
        wait_for_results();
        i_modulus_we <= 1'b1;
        i_modulus <= m;
        @(posedge i_clk);
        i_modulus_we <= 1'b0;
        modulus_now = m;
        modulus_loads++;
    endtask

    function automatic t_word pick_modulus(input int phase);
        case (phase)
            0: return WORD_MAX;
            1: return t_word'($urandom);
            2: return t_word'($urandom_range(2, 64));
            3: return 32'd1;
            4: return BIG_PRIME;
            5: return 32'h8000_0000;
            6: return t_word'($urandom) | 32'd1;
            7: return 32'd0;
            8: return t_word'($urandom_range(2, 4));
            default: return t_word'($urandom);
        endcase
    endfunction

    function automatic t_word pick_value(input t_word m);
        if (m == '0) begin
            return t_word'($urandom);
        end
        case ($urandom_range(0, 9))
            0: return '0;
            1: return WORD_MAX;
            2: return m - 1;
            3: return m;
            4, 5: return t_word'($urandom) % m;
            6: return t_word'($urandom_range(1, 4)) * t_word'($urandom_range(2, 6));
            default: return t_word'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin : check_results
        t_inv_result want;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if ((start && !busy) || o_done) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("modular_inverse: mismatch");
                $finish;
            end
            if (o_done) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: inverse %h no_inverse %b", o_inverse,
                           o_no_inverse);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    checked_count++;
                    if (o_no_inverse) begin
                        flagged_count++;
                    end
                    if (o_inverse !== want.inverse) begin
                        $error("inverse: expected %h, actual %h", want.inverse, o_inverse);
                        error_count++;
                    end
                    if (o_no_inverse !== want.no_inverse) begin
                        $error("no_inverse: expected %b, actual %b", want.no_inverse,
                               o_no_inverse);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        t_inv_result want;
        t_word v;
        int burst;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_value = '0;
        i_modulus_we = 1'b0;
        i_modulus = '0;
        modulus_now = 32'd1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_ROWS; r++) begin
            if (DIRECTED[r].load) begin
                load_modulus(DIRECTED[r].modulus);
            end
            if (DIRECTED[r].typed) begin
                want.inverse = DIRECTED[r].inverse;
                want.no_inverse = DIRECTED[r].no_inverse;
            end else begin
                want = calc_inverse(modulus_now, DIRECTED[r].value);
            end
            send_value(DIRECTED[r].value, $urandom_range(0, 11), want);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            load_modulus(pick_modulus(p));
            burst = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                v = pick_value(modulus_now);
                send_value(v, burst ? 0 : $urandom_range(0, 11), calc_inverse(modulus_now, v));
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Checked %0d transactions over %0d modulus loads, including 0, 1 and 2^32-1.",
                 checked_count, modulus_loads);
        $display("%0d results were flagged as having no inverse.", flagged_count);
        if (error_count == 0) begin
            $display("modular_inverse: match");
        end else begin
            $display("modular_inverse: mismatch");
        end
        $finish;
    end

endmodule
